// File: hdl/avralu_pkg.sv
// Shared types, opcode constants and flag arithmetic for the AVR ALU execute unit.
package avralu_pkg;

  // Status register bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_V = 3;
  localparam int unsigned FLAG_S = 4;
  localparam int unsigned FLAG_H = 5;

  // Major opcode in bits 15:12
  localparam logic [3:0] OP_GRP0  = 4'h0;
  localparam logic [3:0] OP_GRP1  = 4'h1;
  localparam logic [3:0] OP_LOGIC = 4'h2;
  localparam logic [3:0] OP_CPI   = 4'h3;
  localparam logic [3:0] OP_SBCI  = 4'h4;
  localparam logic [3:0] OP_SUBI  = 4'h5;
  localparam logic [3:0] OP_ORI   = 4'h6;
  localparam logic [3:0] OP_ANDI  = 4'h7;
  localparam logic [3:0] OP_GRP9  = 4'h9;
  localparam logic [3:0] OP_LDI   = 4'hE;

  // Function code in bits 11:10, group 0
  localparam logic [1:0] G0_MISC = 2'd0;
  localparam logic [1:0] G0_CPC  = 2'd1;
  localparam logic [1:0] G0_SBC  = 2'd2;
  localparam logic [1:0] G0_ADD  = 2'd3;
  // group 1
  localparam logic [1:0] G1_CPSE = 2'd0;
  localparam logic [1:0] G1_CP   = 2'd1;
  localparam logic [1:0] G1_SUB  = 2'd2;
  localparam logic [1:0] G1_ADC  = 2'd3;
  // logic group
  localparam logic [1:0] G2_AND  = 2'd0;
  localparam logic [1:0] G2_EOR  = 2'd1;
  localparam logic [1:0] G2_OR   = 2'd2;
  localparam logic [1:0] G2_MOV  = 2'd3;

  // Bits 9:8 of the group 0 miscellaneous row
  localparam logic [1:0] M_NOP  = 2'd0;
  localparam logic [1:0] M_MOVW = 2'd1;
  localparam logic [1:0] M_MULS = 2'd2;
  localparam logic [1:0] M_FMUL = 2'd3;

  // Multiply selector {bit7, bit3} in the fractional row
  localparam logic [1:0] MS_MULSU  = 2'd0;
  localparam logic [1:0] MS_FMUL   = 2'd1;
  localparam logic [1:0] MS_FMULS  = 2'd2;
  localparam logic [1:0] MS_FMULSU = 2'd3;

  // Single-operand sub-codes in bits 3:0 of the 1001010 row
  localparam logic [3:0] SG_COM    = 4'h0;
  localparam logic [3:0] SG_NEG    = 4'h1;
  localparam logic [3:0] SG_SWAP   = 4'h2;
  localparam logic [3:0] SG_INC    = 4'h3;
  localparam logic [3:0] SG_ASR    = 4'h5;
  localparam logic [3:0] SG_LSR    = 4'h6;
  localparam logic [3:0] SG_ROR    = 4'h7;
  localparam logic [3:0] SG_FLAG   = 4'h8;
  localparam logic [3:0] SG_DEC    = 4'hA;

  // Result payload, first field in the highest bits
  typedef struct packed {
    logic       skip_next;
    logic [7:0] status_flags;
    logic       pair_write;
    logic [7:0] pair_value;
    logic       dest_write;
    logic [7:0] dest_value;
    logic [4:0] dest_index;
  } exe_result_t;

  typedef struct packed {
    logic [7:0] res;
    logic [7:0] sreg;
  } alu_out_t;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] sreg;
  } mul_out_t;

  // Update N, V, S and Z from a result byte
  function automatic logic [7:0] set_nvs(input logic [7:0] sreg, input logic [7:0] res,
                                         input logic v);
    logic [7:0] s;
    s = sreg;
    s[FLAG_N] = res[7];
    s[FLAG_V] = v;
    s[FLAG_S] = res[7] ^ v;
    s[FLAG_Z] = (res == 8'h00);
    return s;
  endfunction

  function automatic alu_out_t alu_add(input logic [7:0] a, input logic [7:0] b,
                                       input logic cin, input logic [7:0] sreg);
    logic [8:0] sum;
    logic [4:0] hsum;
    alu_out_t   o;
    sum  = {1'b0, a} + {1'b0, b} + {8'b0, cin};
    hsum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
    o.res  = sum[7:0];
    o.sreg = set_nvs(sreg, sum[7:0], ~(a[7] ^ b[7]) & (a[7] ^ sum[7]));
    o.sreg[FLAG_H] = hsum[4];
    o.sreg[FLAG_C] = sum[8];
    return o;
  endfunction

  function automatic alu_out_t alu_sub(input logic [7:0] a, input logic [7:0] b,
                                       input logic cin, input logic chain,
                                       input logic [7:0] sreg);
    logic [8:0] diff;
    alu_out_t   o;
    diff   = {1'b0, a} - {1'b0, b} - {8'b0, cin};
    o.res  = diff[7:0];
    o.sreg = set_nvs(sreg, diff[7:0], (a[7] ^ b[7]) & (a[7] ^ diff[7]));
    o.sreg[FLAG_H] = (({1'b0, b[3:0]} + {4'b0, cin}) > {1'b0, a[3:0]});
    o.sreg[FLAG_C] = (({1'b0, b} + {8'b0, cin}) > {1'b0, a});
    // carry-chained forms keep Z only while every byte is zero
    if (chain) begin
      o.sreg[FLAG_Z] = sreg[FLAG_Z] & (diff[7:0] == 8'h00);
    end
    return o;
  endfunction

  function automatic mul_out_t alu_mul(input logic [7:0] a, input logic [7:0] b,
                                       input logic sa, input logic sb, input logic frac,
                                       input logic [7:0] sreg);
    logic signed [8:0]  x;
    logic signed [8:0]  y;
    logic signed [17:0] p;
    logic [15:0]        q;
    mul_out_t           o;
    x = signed'({sa & a[7], a});
    y = signed'({sb & b[7], b});
    p = x * y;
    q = p[15:0];
    o.sreg = sreg;
    o.sreg[FLAG_C] = q[15];
    if (frac) begin
      q = {q[14:0], 1'b0};
    end
    o.sreg[FLAG_Z] = (q == 16'h0000);
    o.lo = q[7:0];
    o.hi = q[15:8];
    return o;
  endfunction

endpackage

// File: hdl/avr_register_alu_execute_unit.sv
// AVR register/immediate ALU execute unit with register file and status register.
//
//  channel   direction  tdata                                   tuser
//  in_       slave      instr_word[15:0]                        -
//  out_      master     dest/pair writes, status, skip [31:0]   unsupported
//
// One instruction is accepted every cycle while in_tready is high; its result passes the
// read stage and then the output register: the register file banks are read at the
// accepting edge and the execute logic loads the output register as the read stage moves
// on. Writes of the retiring instruction are forwarded to the one read in the same
// cycle. Reset clears the status register and the per-register valid bits at once (no
// clearing pass); a register never written reads as zero. A stalled output holds one
// result and one more instruction in the read stage, then in_tready drops.
module avr_register_alu_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] instr_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [4:0] dest_index, [12:5] dest_value, [13] dest_write,
                                  // [21:14] pair_value, [22] pair_write,
                                  // [30:23] status_flags, [31] skip_next
  output logic        out_tuser   // [0] unsupported
);

  import avralu_pkg::*;

  logic        in_acc;
  logic        s1_fire;
  logic [4:0]  a_idx;
  logic [4:0]  b_idx;

  logic        s1_vld_r;
  logic [15:0] s1_word_r;
  logic [4:0]  s1_aidx_r;
  logic [4:0]  s1_bidx_r;

  logic        fwd_ea_r, fwd_oa_r, fwd_eb_r, fwd_ob_r;
  logic [7:0]  fwd_ea_d_r, fwd_oa_d_r, fwd_eb_d_r, fwd_ob_d_r;

  logic [7:0]  q_ea, q_oa, q_eb, q_ob;
  logic [7:0]  ea, oa, eb, ob;
  logic [7:0]  a_val, b_val;

  logic [31:0] vld_r;
  logic [7:0]  status_r;

  exe_result_t res;
  logic        res_unsup;
  logic [7:0]  sreg_nxt;

  logic        we_even, we_odd;
  logic [3:0]  waddr;
  logic [7:0]  wd_even, wd_odd;

  exe_result_t out_data_r;
  logic        out_unsup_r;
  logic        out_vld_r;

  // Handshake: the read stage moves on when the output register is free
  assign s1_fire   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_fire;
  assign in_acc    = in_tvalid && in_tready;

  // Decode register file read addresses from the incoming word
  always_comb begin
    logic [15:0] w;
    w     = in_tdata;
    a_idx = w[8:4];
    b_idx = {w[9], w[3:0]};
    priority if (w[15:12] == OP_CPI || w[15:12] == OP_SBCI || w[15:12] == OP_SUBI ||
                 w[15:12] == OP_ORI || w[15:12] == OP_ANDI || w[15:12] == OP_LDI) begin
      a_idx = {1'b1, w[7:4]};
    end else if (w[15:10] == {OP_GRP0, G0_MISC}) begin
      unique case (w[9:8])
        M_MOVW: b_idx = {w[3:0], 1'b0};
        M_MULS: begin
          a_idx = {1'b1, w[7:4]};
          b_idx = {1'b1, w[3:0]};
        end
        M_FMUL: begin
          a_idx = {2'b10, w[6:4]};
          b_idx = {2'b10, w[2:0]};
        end
        default: ;
      endcase
    end else begin
    end
  end

  // Register file: even and odd banks so both bytes of a pair are written in the same cycle
  avralu_ram #(.WIDTH(8), .DEPTH(16)) u_ram_even (
    .clk     (clk),
    .we      (we_even),
    .waddr   (waddr),
    .wdata   (wd_even),
    .re      (in_acc),
    .raddr_a (a_idx[4:1]),
    .raddr_b (b_idx[4:1]),
    .rdata_a (q_ea),
    .rdata_b (q_eb)
  );

  avralu_ram #(.WIDTH(8), .DEPTH(16)) u_ram_odd (
    .clk     (clk),
    .we      (we_odd),
    .waddr   (waddr),
    .wdata   (wd_odd),
    .re      (in_acc),
    .raddr_a (a_idx[4:1]),
    .raddr_b (b_idx[4:1]),
    .rdata_a (q_oa),
    .rdata_b (q_ob)
  );

  // Read stage: hold the word, addresses and forwarded write data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fwd_ea_r <= 1'b0;
      fwd_oa_r <= 1'b0;
      fwd_eb_r <= 1'b0;
      fwd_ob_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
        fwd_ea_r <= we_even && (waddr == a_idx[4:1]);
        fwd_eb_r <= we_even && (waddr == b_idx[4:1]);
        fwd_oa_r <= we_odd && (waddr == a_idx[4:1]);
        fwd_ob_r <= we_odd && (waddr == b_idx[4:1]);
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r  <= in_tdata;
      s1_aidx_r  <= a_idx;
      s1_bidx_r  <= b_idx;
      fwd_ea_d_r <= wd_even;
      fwd_eb_d_r <= wd_even;
      fwd_oa_d_r <= wd_odd;
      fwd_ob_d_r <= wd_odd;
    end
  end

  // Select operands: forwarded write, stored value, or zero if never written
  assign ea = fwd_ea_r ? fwd_ea_d_r : (vld_r[{s1_aidx_r[4:1], 1'b0}] ? q_ea : 8'h00);
  assign oa = fwd_oa_r ? fwd_oa_d_r : (vld_r[{s1_aidx_r[4:1], 1'b1}] ? q_oa : 8'h00);
  assign eb = fwd_eb_r ? fwd_eb_d_r : (vld_r[{s1_bidx_r[4:1], 1'b0}] ? q_eb : 8'h00);
  assign ob = fwd_ob_r ? fwd_ob_d_r : (vld_r[{s1_bidx_r[4:1], 1'b1}] ? q_ob : 8'h00);
  assign a_val = s1_aidx_r[0] ? oa : ea;
  assign b_val = s1_bidx_r[0] ? ob : eb;

  // Execute the instruction held in the read stage
  always_comb begin
    logic [15:0] w;
    logic [7:0]  k;
    logic [7:0]  sreg;
    logic [7:0]  r;
    logic        c;
    alu_out_t    ao;
    mul_out_t    mo;
    w    = s1_word_r;
    k    = {w[11:8], w[3:0]};
    sreg = status_r;
    r    = 8'h00;
    c    = 1'b0;
    ao   = '0;
    mo   = '0;
    res  = '0;
    res_unsup = 1'b0;
    unique case (w[15:12])
      OP_GRP0: begin
        unique case (w[11:10])
          G0_MISC: begin
            unique case (w[9:8])
              M_NOP: res_unsup = (w != 16'h0000);
              M_MOVW: begin
                res.dest_write = 1'b1;
                res.dest_index = {w[7:4], 1'b0};
                res.dest_value = eb;
                res.pair_write = 1'b1;
                res.pair_value = ob;
              end
              M_MULS: mo = alu_mul(a_val, b_val, 1'b1, 1'b1, 1'b0, sreg);
              M_FMUL: begin
                unique case ({w[7], w[3]})
                  MS_MULSU:  mo = alu_mul(a_val, b_val, 1'b1, 1'b0, 1'b0, sreg);
                  MS_FMUL:   mo = alu_mul(a_val, b_val, 1'b0, 1'b0, 1'b1, sreg);
                  MS_FMULS:  mo = alu_mul(a_val, b_val, 1'b1, 1'b1, 1'b1, sreg);
                  MS_FMULSU: mo = alu_mul(a_val, b_val, 1'b1, 1'b0, 1'b1, sreg);
                  default: ;
                endcase
              end
              default: ;
            endcase
            if (w[9]) begin
              sreg = mo.sreg;
              res.dest_write = 1'b1;
              res.dest_index = 5'd0;
              res.dest_value = mo.lo;
              res.pair_write = 1'b1;
              res.pair_value = mo.hi;
            end
          end
          G0_CPC: begin
            ao = alu_sub(a_val, b_val, sreg[FLAG_C], 1'b1, sreg);
            sreg = ao.sreg;
          end
          G0_SBC: begin
            ao = alu_sub(a_val, b_val, sreg[FLAG_C], 1'b1, sreg);
            sreg = ao.sreg;
            res.dest_write = 1'b1;
            res.dest_index = w[8:4];
            res.dest_value = ao.res;
          end
          G0_ADD: begin
            ao = alu_add(a_val, b_val, 1'b0, sreg);
            sreg = ao.sreg;
            res.dest_write = 1'b1;
            res.dest_index = w[8:4];
            res.dest_value = ao.res;
          end
          default: ;
        endcase
      end
      OP_GRP1: begin
        unique case (w[11:10])
          G1_CPSE: res.skip_next = (a_val == b_val);
          G1_CP: begin
            ao = alu_sub(a_val, b_val, 1'b0, 1'b0, sreg);
            sreg = ao.sreg;
          end
          G1_SUB: begin
            ao = alu_sub(a_val, b_val, 1'b0, 1'b0, sreg);
            sreg = ao.sreg;
            res.dest_write = 1'b1;
            res.dest_index = w[8:4];
            res.dest_value = ao.res;
          end
          G1_ADC: begin
            ao = alu_add(a_val, b_val, sreg[FLAG_C], sreg);
            sreg = ao.sreg;
            res.dest_write = 1'b1;
            res.dest_index = w[8:4];
            res.dest_value = ao.res;
          end
          default: ;
        endcase
      end
      OP_LOGIC: begin
        unique case (w[11:10])
          G2_AND:  r = a_val & b_val;
          G2_EOR:  r = a_val ^ b_val;
          G2_OR:   r = a_val | b_val;
          G2_MOV:  r = b_val;
          default: ;
        endcase
        if (w[11:10] != G2_MOV) begin
          sreg = set_nvs(sreg, r, 1'b0);
        end
        res.dest_write = 1'b1;
        res.dest_index = w[8:4];
        res.dest_value = r;
      end
      OP_CPI: begin
        ao = alu_sub(a_val, k, 1'b0, 1'b0, sreg);
        sreg = ao.sreg;
      end
      OP_SBCI, OP_SUBI: begin
        ao = alu_sub(a_val, k, (w[15:12] == OP_SBCI) & sreg[FLAG_C],
                     w[15:12] == OP_SBCI, sreg);
        sreg = ao.sreg;
        res.dest_write = 1'b1;
        res.dest_index = {1'b1, w[7:4]};
        res.dest_value = ao.res;
      end
      OP_ORI, OP_ANDI: begin
        r = (w[15:12] == OP_ORI) ? (a_val | k) : (a_val & k);
        sreg = set_nvs(sreg, r, 1'b0);
        res.dest_write = 1'b1;
        res.dest_index = {1'b1, w[7:4]};
        res.dest_value = r;
      end
      OP_LDI: begin
        res.dest_write = 1'b1;
        res.dest_index = {1'b1, w[7:4]};
        res.dest_value = k;
      end
      OP_GRP9: begin
        priority if (w[11:10] == 2'b11) begin
          // unsigned multiply into r1:r0
          mo = alu_mul(a_val, b_val, 1'b0, 1'b0, 1'b0, sreg);
          sreg = mo.sreg;
          res.dest_write = 1'b1;
          res.dest_index = 5'd0;
          res.dest_value = mo.lo;
          res.pair_write = 1'b1;
          res.pair_value = mo.hi;
        end else if (w[11:9] == 3'b010) begin
          if (w[3:0] == SG_FLAG) begin
            // set or clear one status bit
            if (!w[8]) begin
              sreg[w[6:4]] = ~w[7];
            end else begin
              res_unsup = 1'b1;
            end
          end else begin
            res.dest_index = w[8:4];
            res.dest_write = 1'b1;
            unique case (w[3:0])
              SG_COM: begin
                r = ~a_val;
                sreg = set_nvs(sreg, r, 1'b0);
                sreg[FLAG_C] = 1'b1;
              end
              SG_NEG: begin
                ao = alu_sub(8'h00, a_val, 1'b0, 1'b0, sreg);
                r = ao.res;
                sreg = ao.sreg;
                sreg[FLAG_H] = ao.res[3] | a_val[3];
              end
              SG_SWAP: r = {a_val[3:0], a_val[7:4]};
              SG_INC: begin
                r = a_val + 8'h01;
                sreg = set_nvs(sreg, r, r == 8'h80);
              end
              SG_ASR, SG_LSR, SG_ROR: begin
                c = a_val[0];
                unique case (w[3:0])
                  SG_ASR:  r = {a_val[7], a_val[7:1]};
                  SG_LSR:  r = {1'b0, a_val[7:1]};
                  default: r = {sreg[FLAG_C], a_val[7:1]};
                endcase
                sreg = set_nvs(sreg, r, r[7] ^ c);
                sreg[FLAG_C] = c;
              end
              SG_DEC: begin
                r = a_val - 8'h01;
                sreg = set_nvs(sreg, r, r == 8'h7f);
              end
              default: begin
                res.dest_index = 5'd0;
                res.dest_write = 1'b0;
                res_unsup = 1'b1;
              end
            endcase
            res.dest_value = res.dest_write ? r : 8'h00;
          end
        end else begin
          res_unsup = 1'b1;
        end
      end
      default: res_unsup = 1'b1;
    endcase
    res.status_flags = sreg;
    sreg_nxt = sreg;
  end

  // Bank write ports: pairs always start on an even register
  assign waddr   = res.dest_index[4:1];
  assign we_even = s1_fire && res.dest_write && !res.dest_index[0];
  assign we_odd  = s1_fire && (res.pair_write || (res.dest_write && res.dest_index[0]));
  assign wd_even = res.dest_value;
  assign wd_odd  = res.pair_write ? res.pair_value : res.dest_value;

  // Retire: update status, valid bits and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r  <= 8'h00;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        status_r  <= sreg_nxt;
        out_vld_r <= 1'b1;
        if (res.dest_write) begin
          vld_r[res.dest_index] <= 1'b1;
        end
        if (res.pair_write) begin
          vld_r[{res.dest_index[4:1], 1'b1}] <= 1'b1;
        end
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r  <= res;
      out_unsup_r <= res_unsup;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_unsup_r;

  // Full read stage behind a stalled output must stop new transactions
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_tready) |-> !in_tready)
    else $error("input accepted while both stages are stalled");

  // An unsupported word changes no register and requests no skip
  a_unsup_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_unsup_r) |->
      (!out_data_r.dest_write && !out_data_r.pair_write && !out_data_r.skip_next))
    else $error("unsupported instruction produced a side effect");

  // A pair write targets an even register and writes its low byte too
  a_pair_even: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.pair_write) |->
      (out_data_r.dest_write && !out_data_r.dest_index[0]))
    else $error("pair write with odd or missing low register");

  // Status register follows the last retired result
  a_status_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (status_r == out_data_r.status_flags))
    else $error("status register differs from the reported flags");

endmodule

// File: hdl/avralu_ram.sv
// Generic RAM: one write port, two registered read ports with read enable.
module avralu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write, and read old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

// File: test/tb_avr_register_alu_execute_unit.sv
// Self-checking testbench for the AVR register/immediate ALU execute unit.
module tb_avr_register_alu_execute_unit;
  import avralu_pkg::*;

  // Row and selector codes that the package leaves unnamed
  localparam logic [2:0] ROW_SINGLE = 3'b010;
  localparam logic [1:0] G9_MUL     = 2'd3;
  localparam int unsigned RANDOM_INSTRS = 1150;

  // Expected outcome of one instruction: result payload plus unsupported marker
  typedef struct packed {
    logic        unsupported;
    exe_result_t res;
  } exec_outcome_t;

  // Architectural copy of the register file and status register; predicts each outcome
  class avr_exec_model;
    logic [7:0]    gpr [32];
    logic [7:0]    sreg;
    exec_outcome_t cur;
    exec_outcome_t pending[$];
    int            errors;

    function new();
      foreach (gpr[i]) gpr[i] = 8'h00;
      sreg   = 8'h00;
      errors = 0;
    endfunction

    function void set_nvz(logic [7:0] r, logic v);
      sreg[FLAG_N] = r[7];
      sreg[FLAG_V] = v;
      sreg[FLAG_S] = r[7] ^ v;
      sreg[FLAG_Z] = (r == 8'h00);
    endfunction

    function void put(logic [4:0] idx, logic [7:0] val);
      gpr[idx]                = val;
      cur.res.dest_index      = idx;
      cur.res.dest_value      = val;
      cur.res.dest_write      = 1'b1;
    endfunction

    function logic [7:0] add_bytes(logic [7:0] a, logic [7:0] b, logic cin);
      logic [8:0] sum;
      logic [4:0] half;
      sum  = {1'b0, a} + {1'b0, b} + {8'b0, cin};
      half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
      set_nvz(sum[7:0], (a[7] == b[7]) && (sum[7] != a[7]));
      sreg[FLAG_H] = half[4];
      sreg[FLAG_C] = sum[8];
      return sum[7:0];
    endfunction

    function logic [7:0] sub_bytes(logic [7:0] a, logic [7:0] b, logic cin, logic chain);
      logic       z_prev;
      logic [7:0] diff;
      z_prev = sreg[FLAG_Z];
      diff   = a - b - {7'b0, cin};
      set_nvz(diff, (a[7] != b[7]) && (diff[7] != a[7]));
      sreg[FLAG_H] = ({1'b0, b[3:0]} + {4'b0, cin}) > {1'b0, a[3:0]};
      sreg[FLAG_C] = ({1'b0, b} + {8'b0, cin}) > {1'b0, a};
      // chained compares keep Z only while every byte so far was zero
      if (chain) sreg[FLAG_Z] = z_prev && (diff == 8'h00);
      return diff;
    endfunction

    function logic [7:0] logic_flags(logic [7:0] r);
      set_nvz(r, 1'b0);
      return r;
    endfunction

    // Product into r1:r0; fractional forms take C before the shift
    function void multiply(logic [7:0] a, logic [7:0] b, logic sa, logic sb, logic frac);
      int         x;
      int         y;
      logic [15:0] p;
      x = (sa && a[7]) ? int'(a) - 256 : int'(a);
      y = (sb && b[7]) ? int'(b) - 256 : int'(b);
      p = 16'(x * y);
      sreg[FLAG_C] = p[15];
      if (frac) p = {p[14:0], 1'b0};
      sreg[FLAG_Z] = (p == 16'h0000);
      put(5'd0, p[7:0]);
      gpr[1]             = p[15:8];
      cur.res.pair_value = p[15:8];
      cur.res.pair_write = 1'b1;
    endfunction

    // Execute one accepted instruction and queue its expected outcome
    function void execute_instr(logic [15:0] w);
      logic [4:0] d5;
      logic [4:0] r5;
      logic [4:0] d4;
      logic [7:0] k;
      logic [7:0] rd;
      logic [7:0] rr;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] r;
      logic [1:0] fn;
      logic       c;
      cur = '0;
      d5  = w[8:4];
      r5  = {w[9], w[3:0]};
      d4  = {1'b1, w[7:4]};
      k   = {w[11:8], w[3:0]};
      rd  = gpr[d5];
      rr  = gpr[r5];
      fn  = w[11:10];
      case (w[15:12])
        OP_GRP0: begin
          case (fn)
            G0_MISC: begin
              case (w[9:8])
                M_NOP: cur.unsupported = (w != 16'h0000);
                M_MOVW: begin
                  a = gpr[{w[3:0], 1'b0}];
                  b = gpr[{w[3:0], 1'b1}];
                  put({w[7:4], 1'b0}, a);
                  gpr[{w[7:4], 1'b1}] = b;
                  cur.res.pair_value  = b;
                  cur.res.pair_write  = 1'b1;
                end
                M_MULS: multiply(gpr[d4], gpr[{1'b1, w[3:0]}], 1'b1, 1'b1, 1'b0);
                default: begin
                  a = gpr[{2'b10, w[6:4]}];
                  b = gpr[{2'b10, w[2:0]}];
                  case ({w[7], w[3]})
                    MS_MULSU: multiply(a, b, 1'b1, 1'b0, 1'b0);
                    MS_FMUL:  multiply(a, b, 1'b0, 1'b0, 1'b1);
                    MS_FMULS: multiply(a, b, 1'b1, 1'b1, 1'b1);
                    default:  multiply(a, b, 1'b1, 1'b0, 1'b1);
                  endcase
                end
              endcase
            end
            G0_CPC:  void'(sub_bytes(rd, rr, sreg[FLAG_C], 1'b1));
            G0_SBC:  put(d5, sub_bytes(rd, rr, sreg[FLAG_C], 1'b1));
            default: put(d5, add_bytes(rd, rr, 1'b0));
          endcase
        end
        OP_GRP1: begin
          case (fn)
            G1_CPSE: cur.res.skip_next = (rd == rr);
            G1_CP:   void'(sub_bytes(rd, rr, 1'b0, 1'b0));
            G1_SUB:  put(d5, sub_bytes(rd, rr, 1'b0, 1'b0));
            default: put(d5, add_bytes(rd, rr, sreg[FLAG_C]));
          endcase
        end
        OP_LOGIC: begin
          case (fn)
            G2_AND:  put(d5, logic_flags(rd & rr));
            G2_EOR:  put(d5, logic_flags(rd ^ rr));
            G2_OR:   put(d5, logic_flags(rd | rr));
            default: put(d5, rr);
          endcase
        end
        OP_CPI:  void'(sub_bytes(gpr[d4], k, 1'b0, 1'b0));
        OP_SBCI: put(d4, sub_bytes(gpr[d4], k, sreg[FLAG_C], 1'b1));
        OP_SUBI: put(d4, sub_bytes(gpr[d4], k, 1'b0, 1'b0));
        OP_ORI:  put(d4, logic_flags(gpr[d4] | k));
        OP_ANDI: put(d4, logic_flags(gpr[d4] & k));
        OP_LDI:  put(d4, k);
        OP_GRP9: begin
          if (fn == G9_MUL) begin
            multiply(rd, rr, 1'b0, 1'b0, 1'b0);
          end else if (w[11:9] == ROW_SINGLE) begin
            case (w[3:0])
              SG_COM: begin
                r = logic_flags(~rd);
                sreg[FLAG_C] = 1'b1;
                put(d5, r);
              end
              SG_NEG: begin
                r = sub_bytes(8'h00, rd, 1'b0, 1'b0);
                sreg[FLAG_H] = r[3] | rd[3];
                put(d5, r);
              end
              SG_SWAP: put(d5, {rd[3:0], rd[7:4]});
              SG_INC: begin
                r = rd + 8'd1;
                set_nvz(r, r == 8'h80);
                put(d5, r);
              end
              SG_ASR, SG_LSR, SG_ROR: begin
                c = rd[0];
                if (w[3:0] == SG_ASR)      r = {rd[7], rd[7:1]};
                else if (w[3:0] == SG_LSR) r = {1'b0, rd[7:1]};
                else                       r = {sreg[FLAG_C], rd[7:1]};
                set_nvz(r, r[7] ^ c);
                sreg[FLAG_C] = c;
                put(d5, r);
              end
              SG_DEC: begin
                r = rd - 8'd1;
                set_nvz(r, r == 8'h7f);
                put(d5, r);
              end
              SG_FLAG: begin
                // bset / bclr; the other half of the row is outside the set
                if (!w[8]) sreg[w[6:4]] = !w[7];
                else       cur.unsupported = 1'b1;
              end
              default: cur.unsupported = 1'b1;
            endcase
          end else begin
            cur.unsupported = 1'b1;
          end
        end
        default: cur.unsupported = 1'b1;
      endcase
      cur.res.status_flags = sreg;
      pending.push_back(cur);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one result transaction against the oldest expectation
    function void check_outcome(logic [31:0] data, logic user);
      exe_result_t   got;
      exec_outcome_t want;
      got = data;
      if (pending.size() == 0) begin
        $error("result transaction with no instruction outstanding: 0x%0h", data);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("dest_index",   8'(want.res.dest_index), 8'(got.dest_index));
      compare_field("dest_value",   want.res.dest_value,     got.dest_value);
      compare_field("dest_write",   8'(want.res.dest_write), 8'(got.dest_write));
      compare_field("pair_value",   want.res.pair_value,     got.pair_value);
      compare_field("pair_write",   8'(want.res.pair_write), 8'(got.pair_write));
      compare_field("status_flags", want.res.status_flags,   got.status_flags);
      compare_field("skip_next",    8'(want.res.skip_next),  8'(got.skip_next));
      compare_field("unsupported",  8'(want.unsupported),    8'(user));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'h0000;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  int            in_idle_max = 0;
  int            out_idle_max = 0;
  avr_exec_model sb;

  avr_register_alu_execute_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Instruction encoders
  function automatic logic [15:0] enc_rr(logic [3:0] op, logic [1:0] fn, logic [4:0] d,
                                         logic [4:0] r);
    return {op, fn, r[4], d, r[3:0]};
  endfunction

  function automatic logic [15:0] enc_imm(logic [3:0] op, logic [3:0] d, logic [7:0] k);
    return {op, k[7:4], d, k[3:0]};
  endfunction

  function automatic logic [15:0] enc_single(logic [3:0] code, logic [4:0] d);
    return {OP_GRP9, ROW_SINGLE, d, code};
  endfunction

  function automatic logic [15:0] enc_misc(logic [1:0] row, logic [7:0] operands);
    return {OP_GRP0, G0_MISC, row, operands};
  endfunction

  function automatic logic [15:0] enc_sreg_bit(logic clear, logic [2:0] bit_idx);
    return {OP_GRP9, ROW_SINGLE, 1'b0, clear, bit_idx, SG_FLAG};
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5, 0))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_idle_max();
    case ($urandom_range(2, 0))
      0:       return 0;
      1:       return 3;
      default: return 10;
    endcase
  endfunction

  // Mostly well-formed ALU instructions with random operands, some raw noise
  function automatic logic [15:0] random_instr();
    logic [3:0] single_codes [8];
    logic [4:0] d;
    logic [4:0] r;
    int         sel;
    single_codes = '{SG_COM, SG_NEG, SG_SWAP, SG_INC, SG_ASR, SG_LSR, SG_ROR, SG_DEC};
    d   = 5'($urandom);
    r   = 5'($urandom);
    sel = $urandom_range(99, 0);
    if (sel < 12) begin
      return enc_imm(OP_LDI, d[3:0], pick_byte());
    end else if (sel < 40) begin
      case ($urandom_range(2, 0))
        0:       return enc_rr(OP_GRP0, 2'($urandom_range(3, 1)), d, r);
        1:       return enc_rr(OP_GRP1, 2'($urandom), d, r);
        default: return enc_rr(OP_LOGIC, 2'($urandom), d, r);
      endcase
    end else if (sel < 54) begin
      case ($urandom_range(4, 0))
        0:       return enc_imm(OP_CPI,  d[3:0], pick_byte());
        1:       return enc_imm(OP_SBCI, d[3:0], pick_byte());
        2:       return enc_imm(OP_SUBI, d[3:0], pick_byte());
        3:       return enc_imm(OP_ORI,  d[3:0], pick_byte());
        default: return enc_imm(OP_ANDI, d[3:0], pick_byte());
      endcase
    end else if (sel < 70) begin
      if ($urandom_range(4, 0) == 0) return enc_single(4'($urandom), d);
      return enc_single(single_codes[3'($urandom_range(7, 0))], d);
    end else if (sel < 75) begin
      return enc_sreg_bit(1'($urandom), 3'($urandom));
    end else if (sel < 86) begin
      case ($urandom_range(3, 0))
        0:       return enc_rr(OP_GRP9, G9_MUL, d, r);
        1:       return enc_misc(M_MULS, 8'($urandom));
        2:       return enc_misc(M_FMUL, 8'($urandom));
        default: return enc_misc(M_MOVW, 8'($urandom));
      endcase
    end else if (sel < 90) begin
      return {8'h00, 8'($urandom)};
    end
    return 16'($urandom);
  endfunction

  // Offer one instruction after a random gap and hold it until accepted
  task automatic send_instr(input logic [15:0] word);
    int gap;
    gap = $urandom_range(in_idle_max, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.execute_instr(word);
  endtask

  // Main sequence: reset, directed instructions, random instructions, drain
  initial begin
    logic [15:0] stim[$];
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // seed operands at the byte extremes
    stim.push_back(16'h0000);
    stim.push_back(enc_imm(OP_LDI, 4'd0,  8'hff));
    stim.push_back(enc_imm(OP_LDI, 4'd1,  8'h80));
    stim.push_back(enc_imm(OP_LDI, 4'd2,  8'h7f));
    stim.push_back(enc_imm(OP_LDI, 4'd15, 8'h00));
    // two-register arithmetic with carry, overflow and chained zero
    stim.push_back(enc_rr(OP_GRP0, G0_ADD, 5'd16, 5'd17));
    stim.push_back(enc_rr(OP_GRP1, G1_ADC, 5'd18, 5'd16));
    stim.push_back(enc_rr(OP_GRP1, G1_SUB, 5'd17, 5'd18));
    stim.push_back(enc_rr(OP_GRP1, G1_CP,  5'd31, 5'd31));
    stim.push_back(enc_rr(OP_GRP0, G0_CPC, 5'd31, 5'd0));
    stim.push_back(enc_rr(OP_GRP0, G0_SBC, 5'd16, 5'd31));
    stim.push_back(enc_rr(OP_GRP1, G1_CPSE, 5'd31, 5'd31));
    stim.push_back(enc_rr(OP_LOGIC, G2_AND, 5'd16, 5'd17));
    stim.push_back(enc_rr(OP_LOGIC, G2_EOR, 5'd18, 5'd17));
    stim.push_back(enc_rr(OP_LOGIC, G2_OR,  5'd31, 5'd18));
    stim.push_back(enc_rr(OP_LOGIC, G2_MOV, 5'd0,  5'd17));
    // immediate forms
    stim.push_back(enc_imm(OP_CPI,  4'd2,  8'hff));
    stim.push_back(enc_imm(OP_SBCI, 4'd0,  8'h00));
    stim.push_back(enc_imm(OP_SUBI, 4'd1,  8'h80));
    stim.push_back(enc_imm(OP_ORI,  4'd15, 8'hf0));
    stim.push_back(enc_imm(OP_ANDI, 4'd15, 8'h0f));
    // pair move and every multiply form
    stim.push_back(enc_misc(M_MOVW, {4'd1, 4'd8}));
    stim.push_back(enc_rr(OP_GRP9, G9_MUL, 5'd17, 5'd17));
    stim.push_back(enc_misc(M_MULS, {4'd1, 4'd1}));
    stim.push_back(enc_misc(M_FMUL, {MS_MULSU[1],  3'd1, MS_MULSU[0],  3'd2}));
    stim.push_back(enc_misc(M_FMUL, {MS_FMUL[1],   3'd1, MS_FMUL[0],   3'd1}));
    stim.push_back(enc_misc(M_FMUL, {MS_FMULS[1],  3'd1, MS_FMULS[0],  3'd1}));
    stim.push_back(enc_misc(M_FMUL, {MS_FMULSU[1], 3'd1, MS_FMULSU[0], 3'd2}));
    // single-operand row
    stim.push_back(enc_single(SG_COM,  5'd0));
    stim.push_back(enc_single(SG_NEG,  5'd1));
    stim.push_back(enc_single(SG_SWAP, 5'd2));
    stim.push_back(enc_single(SG_INC,  5'd18));
    stim.push_back(enc_single(SG_ASR,  5'd17));
    stim.push_back(enc_single(SG_LSR,  5'd16));
    stim.push_back(enc_single(SG_ROR,  5'd31));
    stim.push_back(enc_single(SG_DEC,  5'd31));
    stim.push_back(enc_sreg_bit(1'b0, 3'd7));
    stim.push_back(enc_sreg_bit(1'b1, 3'd0));
    // words outside the set: nop prefix, unused sub-code, system row, all ones
    stim.push_back(16'h0001);
    stim.push_back(enc_single(4'h4, 5'd3));
    stim.push_back(16'h9508);
    stim.push_back(16'hffff);

    repeat (RANDOM_INSTRS) stim.push_back(random_instr());

    foreach (stim[i]) begin
      // change the idle profile of both sides every few dozen transactions
      if (i % 50 == 0) begin
        in_idle_max  = pick_idle_max();
        out_idle_max = pick_idle_max();
      end
      send_instr(stim[i]);
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: stall for a random gap before each transaction
  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = $urandom_range(out_idle_max, 0);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_outcome(out_tdata, out_tuser);
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
